>>> rtl/acle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acle_pkg
// Types and constants for the acked command link engine.
// ----------------------------------------------------------------------------
package acle_pkg;

  localparam logic [1:0] CmdPush = 2'd0;
  localparam logic [1:0] CmdTick = 2'd1;
  localparam logic [1:0] CmdRx   = 2'd2;
  localparam logic [1:0] CmdBoot = 2'd3;

  localparam logic [2:0] KindQueued  = 3'd0;
  localparam logic [2:0] KindDropped = 3'd1;
  localparam logic [2:0] KindFull    = 3'd2;
  localparam logic [2:0] KindByte    = 3'd3;
  localparam logic [2:0] KindEmpty   = 3'd4;
  localparam logic [2:0] KindWinFull = 3'd5;
  localparam logic [2:0] KindIgnored = 3'd6;
  localparam logic [2:0] KindAck     = 3'd7;

  localparam logic [7:0] CodeStart    = 8'h01;
  localparam logic [7:0] CodeAck      = 8'h02;
  localparam logic [7:0] CodeGetAdv   = 8'h10;
  localparam logic [7:0] CodeStartAdv = 8'h11;
  localparam logic [7:0] CodeStopAdv  = 8'h12;
  localparam logic [7:0] CodeGetConn  = 8'h20;
  localparam logic [7:0] CodeSwitch   = 8'h21;
  localparam logic [7:0] CodeGetLed   = 8'h30;
  localparam logic [7:0] ResSuccess   = 8'h00;

  localparam logic [1:0] AdvUnknown = 2'd0;
  localparam logic [1:0] AdvOff     = 2'd1;
  localparam logic [1:0] AdvOn      = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  pkt_code;
    logic [3:0]  pkt_length;
    logic [63:0] pkt_body;
    logic [7:0]  rx_type;
    logic [7:0]  rx_sequence;
    logic [7:0]  rx_body_length;
    logic [7:0]  rx_frame_size;
    logic [7:0]  rx_request;
    logic [7:0]  rx_result;
    logic [7:0]  rx_data0;
    logic [7:0]  rx_data1;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic       boot_done;
    logic [1:0] advertising;
    logic [7:0] connection_id;
    logic [7:0] led_state;
    logic [3:0] link_count;
    logic [7:0] link_mask;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture item, decide
    logic search;    // step window search
    logic commit;    // apply state change
    logic emit_next; // advance frame byte pointer
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
    logic is_frame;   // item produces a frame
    logic frame_last; // current byte is checksum
  } stat_t;

endpackage

>>> rtl/acked_command_link_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acked_command_link_engine_unit
// Client side of an acknowledged command link: command queue, send window,
// frame generator and ack handling.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | acle_pkg::in_item_t
// out     | output    | out_valid_o/out_stall_i | acle_pkg::out_item_t
//
// One item at a time. Before its first result an item passes load, a window
// search (one slot a cycle), commit and prep; a frame then gives one byte a
// cycle while the output is not stalled, up to 12 results.
// Reset clears queue pointers, window and status; queue memory is not reset.
// A stalled result holds; the input stays stalled until the last result goes.
// ----------------------------------------------------------------------------
module acked_command_link_engine_unit #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int WINDOW_SLOTS   = 4,
  parameter int MAX_BODY_BYTES = 8,
  parameter int LINK_LIMIT     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acle_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acle_pkg::out_item_t out_data_o
);
  acle_pkg::ctrl_t ctrl;
  acle_pkg::stat_t stat;

  acle_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  acle_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .WINDOW_SLOTS(WINDOW_SLOTS),
    .MAX_BODY_BYTES(MAX_BODY_BYTES), .LINK_LIMIT(LINK_LIMIT)
  ) u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .ctrl_i(ctrl), .stat_o(stat),
    .res_o(out_data_o)
  );
endmodule

>>> rtl/acle_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acle_datapath
// Queue memory, window slots, status registers and frame byte generator.
// ----------------------------------------------------------------------------
module acle_datapath #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int WINDOW_SLOTS   = 4,
  parameter int MAX_BODY_BYTES = 8,
  parameter int LINK_LIMIT     = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acle_pkg::in_item_t item_i,
  input  acle_pkg::ctrl_t    ctrl_i,
  output acle_pkg::stat_t    stat_o,
  output acle_pkg::out_item_t res_o
);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int WW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CW = $clog2(WINDOW_SLOTS + 1);

  logic [19:0] hdr_mem [QUEUE_DEPTH];
  logic [63:0] body_mem [QUEUE_DEPTH];
  logic [QW-1:0] head_q, tail_q, nt;
  logic [7:0] seq_q;
  logic [7:0] slot_q [WINDOW_SLOTS];
  logic boot_q;
  logic [1:0] adv_q;
  logic [7:0] conn_q, led_q, mask_q;
  logic [3:0] cnt_q;

  acle_pkg::in_item_t it_q;
  logic [2:0] kind_q;
  logic is_frame_q;
  logic [7:0] f_code_q, f_seq_q, sum_q;
  logic [3:0] f_len_q, pos_q;
  logic [63:0] f_body_q;
  logic [CW-1:0] scan_q;
  logic found_q;
  logic [WW-1:0] hit_q;

  // registered queue read at head
  logic [19:0] rd_hdr_q;
  logic [63:0] rd_body_q;
  always_ff @(posedge clk_i) begin
    rd_hdr_q  <= hdr_mem[head_q];
    rd_body_q <= body_mem[head_q];
  end

  assign nt = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  logic [3:0] len_sat;
  logic [63:0] body_msk;
  always_comb begin
    len_sat = (item_i.pkt_length > 4'(MAX_BODY_BYTES)) ? 4'(MAX_BODY_BYTES)
                                                      : item_i.pkt_length;
    for (int b = 0; b < 8; b++)
      body_msk[b*8 +: 8] = (4'(b) < len_sat) ? item_i.pkt_body[b*8 +: 8] : 8'h00;
  end

  logic rx_bad;
  assign rx_bad = (item_i.rx_frame_size < 8'd3) ||
                  ((9'(item_i.rx_body_length) + 9'd4) != 9'(item_i.rx_frame_size)) ||
                  (item_i.rx_type != acle_pkg::CodeAck);

  logic [7:0] scan_val, key;
  assign scan_val = slot_q[scan_q[WW-1:0]];
  // tick searches for an empty slot, ack for its sequence
  assign key = (it_q.command == acle_pkg::CmdTick) ? 8'h00 : it_q.rx_sequence;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; seq_q <= 8'd1;
      for (int s = 0; s < WINDOW_SLOTS; s++) slot_q[s] <= 8'h00;
      boot_q <= 1'b0; adv_q <= acle_pkg::AdvUnknown;
      conn_q <= '0; led_q <= '0; cnt_q <= '0; mask_q <= '0;
      kind_q <= '0; is_frame_q <= 1'b0; scan_q <= '0; found_q <= 1'b0;
      hit_q <= '0; pos_q <= '0; sum_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        is_frame_q <= 1'b0; scan_q <= '0; found_q <= 1'b0; pos_q <= '0;
        unique case (item_i.command)
          acle_pkg::CmdPush: begin
            if (head_q == nt) kind_q <= acle_pkg::KindFull;
            else if (!boot_q) kind_q <= acle_pkg::KindDropped;
            else begin
              kind_q <= acle_pkg::KindQueued;
              tail_q <= nt;
              seq_q  <= (seq_q == 8'hFF) ? 8'd1 : seq_q + 8'd1;
            end
          end
          acle_pkg::CmdTick: kind_q <= (head_q == tail_q) ? acle_pkg::KindEmpty
                                                           : acle_pkg::KindByte;
          acle_pkg::CmdRx: kind_q <= rx_bad ? acle_pkg::KindIgnored : acle_pkg::KindAck;
          acle_pkg::CmdBoot: begin
            kind_q <= acle_pkg::KindByte; is_frame_q <= 1'b1;
          end
          default: kind_q <= acle_pkg::KindIgnored;
        endcase
      end
      if (ctrl_i.search && !found_q && scan_q != CW'(WINDOW_SLOTS)) begin
        if (scan_val == key) begin found_q <= 1'b1; hit_q <= scan_q[WW-1:0]; end
        scan_q <= scan_q + 1'b1;
      end
      if (ctrl_i.commit) begin
        if (it_q.command == acle_pkg::CmdTick && kind_q == acle_pkg::KindByte) begin
          // seq from queue is never zero
          if (!found_q) kind_q <= acle_pkg::KindWinFull;
          else begin
            slot_q[hit_q] <= rd_hdr_q[15:8];
            head_q <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            is_frame_q <= 1'b1;
          end
        end
        if (it_q.command == acle_pkg::CmdRx && kind_q == acle_pkg::KindAck) begin
          if (it_q.rx_request == acle_pkg::CodeStart) boot_q <= 1'b1;
          else if (it_q.rx_sequence != 8'h00 && found_q) slot_q[hit_q] <= 8'h00;
          if (it_q.rx_result == acle_pkg::ResSuccess) begin
            unique case (it_q.rx_request)
              acle_pkg::CodeGetAdv:
                adv_q <= (it_q.rx_data0 == 8'h00) ? acle_pkg::AdvOff : acle_pkg::AdvOn;
              acle_pkg::CodeStartAdv: adv_q <= acle_pkg::AdvOn;
              acle_pkg::CodeStopAdv:  adv_q <= acle_pkg::AdvOff;
              acle_pkg::CodeGetConn: begin
                cnt_q  <= (it_q.rx_data0 > 8'(LINK_LIMIT)) ? 4'(LINK_LIMIT)
                                                          : it_q.rx_data0[3:0];
                mask_q <= it_q.rx_data1;
              end
              acle_pkg::CodeSwitch: conn_q <= it_q.rx_data0;
              acle_pkg::CodeGetLed: led_q  <= it_q.rx_data0;
              default: ;
            endcase
          end
        end
        sum_q <= 8'h00;
      end
      if (ctrl_i.emit_next) begin
        sum_q <= sum_q + res_o.out_byte;
        pos_q <= pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      it_q <= item_i;
      if (item_i.command == acle_pkg::CmdPush && head_q != nt && boot_q) begin
        hdr_mem[tail_q]  <= {len_sat, seq_q, item_i.pkt_code};
        body_mem[tail_q] <= body_msk;
      end
    end
    if (ctrl_i.commit) begin
      if (it_q.command == acle_pkg::CmdBoot) begin
        f_code_q <= acle_pkg::CodeStart; f_seq_q <= 8'h00; f_len_q <= 4'd0;
        f_body_q <= '0;
      end else begin
        f_code_q <= rd_hdr_q[7:0]; f_seq_q <= rd_hdr_q[15:8];
        f_len_q <= rd_hdr_q[19:16]; f_body_q <= rd_body_q;
      end
    end
  end

  logic [7:0] fbyte;
  always_comb begin
    if (pos_q == 4'd0) fbyte = f_code_q;
    else if (pos_q == 4'd1) fbyte = f_seq_q;
    else if (pos_q == 4'd2) fbyte = {4'd0, f_len_q};
    else if (pos_q == f_len_q + 4'd3) fbyte = sum_q;
    else fbyte = f_body_q[3'(pos_q - 4'd3)*8 +: 8];
  end

  assign stat_o.search_done = found_q || (scan_q == CW'(WINDOW_SLOTS));
  assign stat_o.is_frame    = is_frame_q;
  assign stat_o.frame_last  = (pos_q == f_len_q + 4'd3);

  assign res_o.out_kind      = is_frame_q ? acle_pkg::KindByte : kind_q;
  assign res_o.out_byte      = is_frame_q ? fbyte : 8'h00;
  assign res_o.out_last      = is_frame_q ? stat_o.frame_last : 1'b1;
  assign res_o.boot_done     = boot_q;
  assign res_o.advertising   = adv_q;
  assign res_o.connection_id = conn_q;
  assign res_o.led_state     = led_q;
  assign res_o.link_count    = cnt_q;
  assign res_o.link_mask     = mask_q;
endmodule

>>> rtl/acle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acle_ctrl
// Sequencer: load, window search, commit, result delivery.
// ----------------------------------------------------------------------------
module acle_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  acle_pkg::stat_t stat_i,
  output acle_pkg::ctrl_t ctrl_o
);
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StSearch = 5'b00010,
    StCommit = 5'b00100,
    StPrep   = 5'b01000,
    StOut    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin ctrl_o.load = 1'b1; state_d = StSearch; end
      end
      StSearch: begin
        ctrl_o.search = 1'b1;
        if (stat_i.search_done) state_d = StCommit;
      end
      StCommit: begin ctrl_o.commit = 1'b1; state_d = StPrep; end
      StPrep: state_d = StOut;
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (stat_i.is_frame && !stat_i.frame_last) ctrl_o.emit_next = 1'b1;
          else state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the acked command link engine. The bench keeps its
// own model of the command queue, send window and link status, predicts the
// results of every accepted item and checks them in order against the
// block's output channel. Stimulus is a directed opening, a stretch of
// push/tick/ack rounds, then random traffic under several idle and stall
// patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QDEPTH     = 8;
  localparam int NSLOTS     = 4;
  localparam int QUIET_MAX  = 3000; // cycles with no item moving on either side
  localparam int HOLD_LEN   = 400;  // long receiver hold-off
  localparam int NRANDOM    = 144;
  localparam int NWRAP      = 30;   // push/tick/ack rounds

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  acle_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  acle_pkg::out_item_t out_data_o;

  acked_command_link_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  acle_pkg::in_item_t  items_q[$];      // items waiting for the driver
  acle_pkg::out_item_t expect_q[$];     // predicted results, oldest first
  acle_pkg::out_item_t step_res[$];     // results of the item being predicted
  int        idle_pct  = 0;   // sender idle chance, percent
  int        stall_pct = 0;   // receiver stall chance, percent
  int        hold_req  = 0;   // bumped by the sequencer to request a hold-off
  int        hold_seen = 0;
  int        hold_left = 0;
  int        err_cnt   = 0;
  int        quiet     = 0;

  // --------------------------------------------------------------------------
  // Link model: queue, send window, status
  // --------------------------------------------------------------------------
  logic [7:0]  cq_code [QDEPTH];
  logic [7:0]  cq_seq  [QDEPTH];
  logic [3:0]  cq_len  [QDEPTH];
  logic [63:0] cq_body [QDEPTH];
  int          cq_head = 0;
  int          cq_tail = 0;
  logic [7:0]  seq_next = 8'd1;
  logic [7:0]  slot_seq [NSLOTS] = '{default: 8'd0};
  logic        st_boot  = 1'b0;
  logic [1:0]  st_adv   = acle_pkg::AdvUnknown;
  logic [7:0]  st_conn  = '0;
  logic [7:0]  st_led   = '0;
  logic [3:0]  st_lcnt  = '0;
  logic [7:0]  st_lmask = '0;

  function automatic void note(logic [2:0] kind, logic [7:0] b);
    acle_pkg::out_item_t r;
    r = '0;
    r.out_kind = kind;
    r.out_byte = b;
    step_res.push_back(r);
  endfunction

  // frame: code, sequence, length, body, additive checksum
  function automatic void note_frame(logic [7:0] code, logic [7:0] seq,
                                     logic [3:0] len, logic [63:0] body);
    logic [7:0] sum;
    sum = code + seq + {4'd0, len};
    note(acle_pkg::KindByte, code);
    note(acle_pkg::KindByte, seq);
    note(acle_pkg::KindByte, {4'd0, len});
    for (int i = 0; i < len; i++) begin
      sum = sum + body[8*i +: 8];
      note(acle_pkg::KindByte, body[8*i +: 8]);
    end
    note(acle_pkg::KindByte, sum);
  endfunction

  function automatic void predict_link(acle_pkg::in_item_t it);
    int          nt;
    int          slot;
    logic [3:0]  len;
    logic [63:0] body;
    logic [7:0]  seq;
    step_res.delete();
    case (it.command)
      acle_pkg::CmdPush: begin
        nt = (cq_tail + 1) % QDEPTH;
        if (cq_head == nt) begin
          note(acle_pkg::KindFull, 8'd0);
        end else if (!st_boot) begin
          note(acle_pkg::KindDropped, 8'd0);
        end else begin
          len  = (it.pkt_length > 4'd8) ? 4'd8 : it.pkt_length;
          body = it.pkt_body;
          if (len < 4'd8) body &= (64'd1 << (8 * len)) - 64'd1;
          cq_code[cq_tail] = it.pkt_code;
          cq_seq[cq_tail]  = seq_next;
          cq_len[cq_tail]  = len;
          cq_body[cq_tail] = body;
          seq_next = (seq_next == 8'd255) ? 8'd1 : seq_next + 8'd1;
          cq_tail = nt;
          note(acle_pkg::KindQueued, 8'd0);
        end
      end
      acle_pkg::CmdTick: begin
        if (cq_head == cq_tail) begin
          note(acle_pkg::KindEmpty, 8'd0);
        end else begin
          seq  = cq_seq[cq_head];
          slot = -1;
          if (seq != 8'd0) begin
            for (int i = NSLOTS - 1; i >= 0; i--) begin
              if (slot_seq[i] == 8'd0) slot = i;
            end
          end
          if (seq != 8'd0 && slot < 0) begin
            note(acle_pkg::KindWinFull, 8'd0);
          end else begin
            if (slot >= 0) slot_seq[slot] = seq;
            note_frame(cq_code[cq_head], seq, cq_len[cq_head], cq_body[cq_head]);
            cq_head = (cq_head + 1) % QDEPTH;
          end
        end
      end
      acle_pkg::CmdBoot: note_frame(acle_pkg::CodeStart, 8'd0, 4'd0, 64'd0);
      default: begin
        if (it.rx_frame_size < 8'd3 ||
            ({1'b0, it.rx_body_length} + 9'd4) != {1'b0, it.rx_frame_size} ||
            it.rx_type != acle_pkg::CodeAck) begin
          note(acle_pkg::KindIgnored, 8'd0);
        end else begin
          if (it.rx_request == acle_pkg::CodeStart) begin
            st_boot = 1'b1;
          end else if (it.rx_sequence != 8'd0) begin
            slot = -1;
            for (int i = NSLOTS - 1; i >= 0; i--) begin
              if (slot_seq[i] == it.rx_sequence) slot = i;
            end
            if (slot >= 0) slot_seq[slot] = 8'd0;
          end
          if (it.rx_result == acle_pkg::ResSuccess) begin
            case (it.rx_request)
              acle_pkg::CodeGetAdv:
                st_adv = (it.rx_data0 == 8'd0) ? acle_pkg::AdvOff : acle_pkg::AdvOn;
              acle_pkg::CodeStartAdv: st_adv = acle_pkg::AdvOn;
              acle_pkg::CodeStopAdv:  st_adv = acle_pkg::AdvOff;
              acle_pkg::CodeGetConn: begin
                st_lcnt  = (it.rx_data0 > 8'd8) ? 4'd8 : it.rx_data0[3:0];
                st_lmask = it.rx_data1;
              end
              acle_pkg::CodeSwitch:   st_conn = it.rx_data0;
              acle_pkg::CodeGetLed:   st_led  = it.rx_data0;
              default: ;
            endcase
          end
          note(acle_pkg::KindAck, 8'd0);
        end
      end
    endcase
    // status fields carry the state after the item, last flag on the final one
    foreach (step_res[i]) begin
      step_res[i].out_last      = (i == step_res.size() - 1);
      step_res[i].boot_done     = st_boot;
      step_res[i].advertising   = st_adv;
      step_res[i].connection_id = st_conn;
      step_res[i].led_state     = st_led;
      step_res[i].link_count    = st_lcnt;
      step_res[i].link_mask     = st_lmask;
      expect_q.push_back(step_res[i]);
    end
  endfunction

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued items, predicts each one as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_link(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (items_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= items_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random, or a long hold-off when requested
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every taken result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    acle_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expect_q.size() == 0) begin
        report($sformatf("unexpected result %p", out_data_o));
      end else begin
        want = expect_q.pop_front();
        if (out_data_o.out_kind !== want.out_kind)
          report($sformatf("out_kind %0d, want %0d", out_data_o.out_kind, want.out_kind));
        if (out_data_o.out_byte !== want.out_byte)
          report($sformatf("out_byte %h, want %h", out_data_o.out_byte, want.out_byte));
        if (out_data_o.out_last !== want.out_last)
          report($sformatf("out_last %b, want %b", out_data_o.out_last, want.out_last));
        if (out_data_o.boot_done !== want.boot_done)
          report($sformatf("boot_done %b, want %b", out_data_o.boot_done, want.boot_done));
        if (out_data_o.advertising !== want.advertising)
          report($sformatf("advertising %0d, want %0d",
                           out_data_o.advertising, want.advertising));
        if (out_data_o.connection_id !== want.connection_id)
          report($sformatf("connection_id %h, want %h",
                           out_data_o.connection_id, want.connection_id));
        if (out_data_o.led_state !== want.led_state)
          report($sformatf("led_state %h, want %h", out_data_o.led_state, want.led_state));
        if (out_data_o.link_count !== want.link_count)
          report($sformatf("link_count %0d, want %0d",
                           out_data_o.link_count, want.link_count));
        if (out_data_o.link_mask !== want.link_mask)
          report($sformatf("link_mask %h, want %h", out_data_o.link_mask, want.link_mask));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with nothing moving means the block has hung
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic acle_pkg::in_item_t mk_push(logic [7:0] code, logic [3:0] len,
                                                 logic [63:0] body);
    acle_pkg::in_item_t it;
    it = '0;
    it.command    = acle_pkg::CmdPush;
    it.pkt_code   = code;
    it.pkt_length = len;
    it.pkt_body   = body;
    return it;
  endfunction

  function automatic acle_pkg::in_item_t mk_cmd(logic [1:0] cmd);
    acle_pkg::in_item_t it;
    it = '0;
    it.command = cmd;
    return it;
  endfunction

  // well-formed ack: size matches declared body length
  function automatic acle_pkg::in_item_t mk_ack(logic [7:0] seq, logic [7:0] req,
                                                logic [7:0] res, logic [7:0] d0,
                                                logic [7:0] d1, logic [7:0] blen);
    acle_pkg::in_item_t it;
    it = '0;
    it.command        = acle_pkg::CmdRx;
    it.rx_type        = acle_pkg::CodeAck;
    it.rx_sequence    = seq;
    it.rx_body_length = blen;
    it.rx_frame_size  = blen + 8'd4;
    it.rx_request     = req;
    it.rx_result      = res;
    it.rx_data0       = d0;
    it.rx_data1       = d1;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(255));
  endfunction

  // a sequence number currently held in the window, if any
  function automatic logic [7:0] live_seq();
    return slot_seq[$urandom_range(NSLOTS - 1)];
  endfunction

  function automatic logic [7:0] rand_req();
    case ($urandom_range(8))
      0: return acle_pkg::CodeStart;
      1: return acle_pkg::CodeGetAdv;
      2: return acle_pkg::CodeStartAdv;
      3: return acle_pkg::CodeStopAdv;
      4: return acle_pkg::CodeGetConn;
      5: return acle_pkg::CodeSwitch;
      6: return acle_pkg::CodeGetLed;
      default: return rand8();
    endcase
  endfunction

  // keeps the driver's queue short so acks see a fresh window
  task automatic send(acle_pkg::in_item_t it);
    while (items_q.size() >= 2) @(posedge clk_i);
    items_q.push_back(it);
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (items_q.size() != 0 || in_valid_i || expect_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    acle_pkg::in_item_t it;
    int       pick;
    int       guard;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    it = mk_ack(8'd0, acle_pkg::CodeStart, acle_pkg::ResSuccess, 8'd0, 8'd0, 8'd0);
    it.rx_frame_size  = 8'd2;   // too short to be a frame
    it.rx_body_length = 8'hFE;
    send(it);
    send(mk_push(8'h55, 4'd3, rand64()));          // before boot: dropped
    send(mk_cmd(acle_pkg::CmdTick));                // empty queue
    send(mk_cmd(acle_pkg::CmdBoot));
    it = mk_ack(8'd5, acle_pkg::CodeGetAdv, acle_pkg::ResSuccess, 8'd0, 8'd0, 8'd2);
    it.rx_frame_size = 8'd7;                        // length disagrees with size
    send(it);
    it = mk_ack(8'd0, acle_pkg::CodeStart, acle_pkg::ResSuccess, 8'd0, 8'd0, 8'd4);
    it.rx_type = 8'h80;                             // not an ack
    send(it);
    send(mk_ack(8'd0, acle_pkg::CodeStart, acle_pkg::ResSuccess,
                8'd0, 8'd0, 8'd4));                 // boot ack
    send(mk_push(8'h00, 4'd0, '1));
    send(mk_push(8'hFF, 4'd8, '1));
    send(mk_push(8'hA5, 4'd15, '1));                // long body saturates
    send(mk_push(8'h3C, 4'd3, rand64()));
    send(mk_push(8'h10, 4'd1, rand64()));
    send(mk_push(8'h20, 4'd7, rand64()));
    send(mk_push(8'h30, 4'd5, rand64()));
    send(mk_push(8'h40, 4'd2, rand64()));           // ring full
    repeat (5) send(mk_cmd(acle_pkg::CmdTick));     // last one finds no slot
    send(mk_ack(8'd1, acle_pkg::CodeGetAdv, acle_pkg::ResSuccess, 8'd0, 8'd0, 8'd4));
    send(mk_ack(8'd0, acle_pkg::CodeStartAdv, acle_pkg::ResSuccess, 8'd0, 8'd0, 8'd4));
    send(mk_ack(8'd200, acle_pkg::CodeGetConn, acle_pkg::ResSuccess,
                8'hFF, 8'hA5, 8'd4));
    send(mk_ack(8'd2, acle_pkg::CodeSwitch, acle_pkg::ResSuccess, 8'hFF, 8'd0, 8'd4));
    send(mk_ack(8'd3, acle_pkg::CodeGetLed, 8'h01, 8'h77, 8'd0, 8'd4)); // failed result
    send(mk_ack(8'd4, acle_pkg::CodeStopAdv, acle_pkg::ResSuccess,
                8'd0, 8'd0, 8'd0));                 // short body
    send(mk_ack(8'd3, acle_pkg::CodeGetLed, acle_pkg::ResSuccess, 8'hFF, 8'd0, 8'd1));
    settle();

    // push/tick/ack rounds
    for (int r = 0; r < NWRAP; r++) begin
      send(mk_push(rand8(), 4'($urandom_range(15)), rand64()));
      send(mk_cmd(acle_pkg::CmdTick));
      it = mk_ack(8'd0, rand_req(),
                  ($urandom_range(3) == 0) ? 8'h01 : acle_pkg::ResSuccess,
                  rand8(), rand8(), 8'($urandom_range(4)));
      if (it.rx_request == acle_pkg::CodeStart) it.rx_request = acle_pkg::CodeGetLed;
      it.rx_sequence = live_seq();
      send(it);
    end
    settle();

    // random traffic in four idle/stall patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 2) hold_req++;
      for (int n = 0; n < NRANDOM / 4; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          it = mk_push(rand8(), 4'($urandom_range(15)), rand64());
        end else if (pick < 60) begin
          it = mk_cmd(acle_pkg::CmdTick);
        end else if (pick < 85) begin
          it = mk_ack(live_seq(), rand_req(),
                      ($urandom_range(4) == 0) ? rand8() : acle_pkg::ResSuccess,
                      rand8(), rand8(), 8'($urandom_range(6)));
        end else if (pick < 90) begin
          it = mk_cmd(acle_pkg::CmdBoot);
        end else begin
          it = '0;
          it.command        = acle_pkg::CmdRx;
          it.rx_type        = ($urandom_range(1) == 0) ? acle_pkg::CodeAck : rand8();
          it.rx_sequence    = rand8();
          it.rx_body_length = rand8();
          it.rx_frame_size  = rand8();
          it.rx_request     = rand8();
          it.rx_result      = rand8();
          it.rx_data0       = rand8();
          it.rx_data1       = rand8();
        end
        send(it);
      end
      // sender pauses here until every predicted result has come out
      settle();
    end

    idle_pct  = 0;
    stall_pct = 0;
    guard = 0;
    while (expect_q.size() != 0 && guard < QUIET_MAX) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/acle_pkg.sv
rtl/acle_datapath.sv
rtl/acle_ctrl.sv
rtl/acked_command_link_engine_unit.sv
verif/tb_top.sv
